FILE: src/qlu_pkg.sv
// ----------------------------------------------------------------------------
// qlu_pkg
// Shared constants, codes and beat types of the tabular Q-learning update.
// ----------------------------------------------------------------------------
`default_nettype none

package qlu_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 8;
  localparam int Q_WIDTH     = 32;
  localparam int FRAC_W      = 16;

  localparam int ST_W   = $clog2(NUM_STATES);
  localparam int ACT_W  = $clog2(NUM_ACTIONS);
  localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [15:0] GAMMA_RST = 16'd62259;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_END   = 2'd2
  } req_e;

  typedef struct packed {
    logic        [1:0]  req_type;
    logic        [7:0]  next_state;
    logic        [2:0]  next_action;
    logic signed [31:0] reward_value;
    logic        [15:0] learning_rate;
  } qlu_req_t;

  typedef struct packed {
    logic signed [31:0] updated_value;
    logic signed [31:0] best_next_value;
    logic               saturated;
    logic        [2:0]  chosen_action;
  } qlu_res_t;

  typedef struct packed {
    logic best_clr;
    logic best_first;
    logic best_upd;
    logic q_load;
    logic gmul_en;
    logic delta_en;
    logic amul_en;
    logic is_step;
  } qlu_ctl_t;

endpackage

`default_nettype wire

FILE: src/qlu_ram.sv
// ----------------------------------------------------------------------------
// qlu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/qlu_arith.sv
// ----------------------------------------------------------------------------
// qlu_arith
// Row maximum, discounted target, alpha-scaled step and saturating sum.
// ----------------------------------------------------------------------------
`default_nettype none

module qlu_arith (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire qlu_pkg::qlu_ctl_t                   ctl_i,
  input  wire logic signed [qlu_pkg::Q_WIDTH-1:0]  rdata_i,
  input  wire logic        [15:0]                  gamma_i,
  input  wire logic signed [31:0]                  reward_i,
  input  wire logic        [15:0]                  alpha_i,
  output logic signed      [qlu_pkg::Q_WIDTH-1:0]  best_o,
  output logic signed      [qlu_pkg::Q_WIDTH-1:0]  value_o,
  output logic                                     sat_o
);

  localparam int QW  = qlu_pkg::Q_WIDTH;
  localparam int FW  = qlu_pkg::FRAC_W;
  localparam int GW  = QW + 17;
  localparam int DW  = QW + 2;
  localparam int AW  = DW + 17;
  localparam int SW  = DW + 2;

  logic signed [QW-1:0] best_q, best_d;
  logic signed [QW-1:0] qcur_q;
  logic signed [GW-1:0] prodg_q;
  logic signed [DW-1:0] delta_q, delta_d;
  logic signed [AW-1:0] proda_q;
  logic signed [QW-1:0] gq;
  logic signed [DW:0]   step;
  logic signed [SW-1:0] sum;
  logic        [SW-QW:0] top;

  always_comb begin
    best_d = best_q;
    if (ctl_i.best_clr) begin
      best_d = '0;
    end else if (ctl_i.best_upd) begin
      if (ctl_i.best_first || (rdata_i > best_q)) begin
        best_d = rdata_i;
      end
    end
  end

  assign gq = prodg_q[FW +: QW];

  always_comb begin
    if (ctl_i.is_step) begin
      delta_d = DW'(reward_i) + DW'(gq) - DW'(qcur_q);
    end else begin
      delta_d = DW'(reward_i) - DW'(qcur_q);
    end
  end

  assign step = proda_q[AW-1:FW];
  assign sum  = SW'(qcur_q) + SW'(step);
  assign top  = sum[SW-1:QW-1];
  assign sat_o = !((&top) || (~|top));

  always_comb begin
    if (sat_o) begin
      value_o = sum[SW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      value_o = sum[QW-1:0];
    end
  end

  assign best_o = best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      qcur_q  <= '0;
      prodg_q <= '0;
      delta_q <= '0;
      proda_q <= '0;
    end else begin
      best_q <= best_d;
      if (ctl_i.q_load) begin
        qcur_q <= rdata_i;
      end
      if (ctl_i.gmul_en) begin
        prodg_q <= best_q * $signed({1'b0, gamma_i});
      end
      if (ctl_i.delta_en) begin
        delta_q <= delta_d;
      end
      if (ctl_i.amul_en) begin
        proda_q <= delta_q * $signed({1'b0, alpha_i});
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/tabular_q_learning_update.sv
// ----------------------------------------------------------------------------
// tabular_q_learning_update
// Q-table update engine for tabular Q-learning with start, step and end beats.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_i) is taken on a clock edge with start high and busy
//   low. Each request gives exactly one result beat on res_o, marked by
//   res_valid_o for one cycle; the receiver cannot stall it.
//   discount_factor is written through cfg_we_i / cfg_wdata_i while idle; the
//   user must keep to this, as the block itself does not enforce it.
//   start or unused request type: the result shows in the next cycle.
//   end:  read of Q(x,u), two multiply stages, write back.
//   step: a row scan through the single read port of the Q-table RAM, one
//   entry per cycle, then the same read, multiply and write-back steps as end.
//   A new request may be accepted in the cycle its predecessor's result shows.
// Reset:
//   Current pair goes to (0,0) and gamma to its reset value, then a clearing
//   pass writes zero to every Q entry, one per cycle, NUM_STATES *
//   NUM_ACTIONS = 2048 entries in all, with busy held high.
// ----------------------------------------------------------------------------
`default_nettype none

module tabular_q_learning_update (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire qlu_pkg::qlu_req_t req_i,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_wdata_i,
  output logic                   res_valid_o,
  output qlu_pkg::qlu_res_t      res_o
);

  localparam int QW     = qlu_pkg::Q_WIDTH;
  localparam int ST_W   = qlu_pkg::ST_W;
  localparam int ACT_W  = qlu_pkg::ACT_W;
  localparam int ADDR_W = qlu_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_CUR,
    S_GMUL,
    S_DELTA,
    S_AMUL,
    S_UPD
  } state_e;

  state_e            state_q;
  qlu_pkg::qlu_req_t req_q;
  logic [ST_W-1:0]   cur_state_q;
  logic [ACT_W-1:0]  cur_action_q;
  logic [15:0]       gamma_q;
  logic [ACT_W-1:0]  idx_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              row_rd_q;
  logic              row_first_q;
  logic              res_valid_q;
  logic              res_valid_d;
  qlu_pkg::qlu_res_t res_q;

  logic              accept;
  logic              is_step;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [QW-1:0]     mem_wdata;
  logic [QW-1:0]     mem_rdata;
  qlu_pkg::qlu_ctl_t ctl;
  logic signed [QW-1:0] best;
  logic signed [QW-1:0] new_value;
  logic              new_sat;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign is_step = (req_q.req_type == qlu_pkg::REQ_STEP);

  assign res_valid_d = (state_q == S_UPD) ||
                       (accept && (req_i.req_type != qlu_pkg::REQ_STEP) &&
                        (req_i.req_type != qlu_pkg::REQ_END));

  always_comb begin
    mem_raddr = (state_q == S_ROW) ? {req_q.next_state[ST_W-1:0], idx_q}
                                   : {cur_state_q, cur_action_q};
    mem_we    = (state_q == S_CLEAR) || (state_q == S_UPD);
    mem_waddr = (state_q == S_CLEAR) ? clr_cnt_q : {cur_state_q, cur_action_q};
    mem_wdata = (state_q == S_CLEAR) ? '0 : new_value;
  end

  always_comb begin
    ctl.best_clr   = accept;
    ctl.best_first = row_first_q;
    ctl.best_upd   = row_rd_q;
    ctl.q_load     = (state_q == S_GMUL);
    ctl.gmul_en    = (state_q == S_GMUL);
    ctl.delta_en   = (state_q == S_DELTA);
    ctl.amul_en    = (state_q == S_AMUL);
    ctl.is_step    = is_step;
  end

  qlu_ram #(
    .DEPTH (qlu_pkg::DEPTH),
    .WIDTH (QW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  qlu_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rdata_i  (mem_rdata),
    .gamma_i  (gamma_q),
    .reward_i (req_q.reward_value),
    .alpha_i  (req_q.learning_rate),
    .best_o   (best),
    .value_o  (new_value),
    .sat_o    (new_sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      req_q        <= '0;
      cur_state_q  <= '0;
      cur_action_q <= '0;
      gamma_q      <= qlu_pkg::GAMMA_RST;
      idx_q        <= '0;
      clr_cnt_q    <= '0;
      row_rd_q     <= 1'b0;
      row_first_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      row_rd_q    <= (state_q == S_ROW);
      row_first_q <= (state_q == S_ROW) && (idx_q == '0);
      if (cfg_we_i) begin
        gamma_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(qlu_pkg::DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q <= req_i;
            idx_q <= '0;
            case (req_i.req_type)
              qlu_pkg::REQ_START: begin
                cur_state_q  <= req_i.next_state[ST_W-1:0];
                cur_action_q <= req_i.next_action[ACT_W-1:0];
                res_q        <= '{updated_value:   '0,
                                  best_next_value: '0,
                                  saturated:       1'b0,
                                  chosen_action:   req_i.next_action};
              end
              qlu_pkg::REQ_STEP: begin
                state_q <= S_ROW;
              end
              qlu_pkg::REQ_END: begin
                state_q <= S_CUR;
              end
              default: begin
                res_q <= '{updated_value:   '0,
                           best_next_value: '0,
                           saturated:       1'b0,
                           chosen_action:   3'(cur_action_q)};
              end
            endcase
          end
        end
        S_ROW: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == ACT_W'(qlu_pkg::NUM_ACTIONS - 1)) begin
            state_q <= S_CUR;
          end
        end
        S_CUR:   state_q <= S_GMUL;
        S_GMUL:  state_q <= S_DELTA;
        S_DELTA: state_q <= S_AMUL;
        S_AMUL:  state_q <= S_UPD;
        S_UPD: begin
          state_q <= S_IDLE;
          res_q   <= '{updated_value:   new_value,
                       best_next_value: is_step ? best : '0,
                       saturated:       new_sat,
                       chosen_action:   is_step ? req_q.next_action
                                                : 3'(cur_action_q)};
          if (is_step) begin
            cur_state_q  <= req_q.next_state[ST_W-1:0];
            cur_action_q <= req_q.next_action[ACT_W-1:0];
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_wr_only_clear_or_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_UPD))
    else $error("Q-table written outside clear or update");

  a_table_op_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.req_type == qlu_pkg::REQ_STEP || req_i.req_type == qlu_pkg::REQ_END))
      |=> !res_valid_o)
    else $error("result beat before the table update finished");

  a_busy_drop_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (res_valid_o || $past(state_q == S_CLEAR)))
    else $error("busy dropped without a result beat");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.saturated) |->
      (res_o.updated_value == {1'b0, {31{1'b1}}} ||
       res_o.updated_value == {1'b1, {31{1'b0}}}))
    else $error("saturated result not at a range limit");

endmodule

`default_nettype wire
